// ----- hw/rtl/tvjt_pkg.sv -----
// Shared types, constants and helper functions of the two-view triangulation core.
`timescale 1ns / 1ps

package tvjt_pkg;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned CONF_W  = 16;
  localparam int unsigned DEPTH_W = 24;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned ROW_W   = 60;
  localparam int unsigned ELEM_W  = 20;

  // Ray components are signed Q4.12, saturated to +-65535.
  localparam int unsigned RAY_W   = 17;
  // Rotated reference ray components.
  localparam int unsigned B_W     = 21;
  // Products and sums of the dot products before the Q.16 shift.
  localparam int unsigned PRD_W   = 48;
  // Dot products after the shift.
  localparam int unsigned DOT_W   = 32;
  // Determinant and numerators.
  localparam int unsigned WIDE_W  = 64;
  localparam int unsigned MAG_W   = 60;
  localparam int unsigned DET_W   = 56;

  localparam logic signed [RAY_W-1:0]  RAY_ONE   = 17'sd4096;
  localparam logic signed [RAY_W-1:0]  RAY_MAX   = 17'sd65535;
  localparam logic signed [WIDE_W-1:0] DET_MIN   = 64'sd4295;
  localparam logic [DEPTH_W-1:0]       DEPTH_SAT = 24'hFFFFFF;
  localparam logic [CONF_W-1:0]        CONF_RST  = 16'd4096;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_ROT0  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROT1  = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROT2  = 3'd2;
  localparam logic [IDX_W-1:0] REG_TRANS = 3'd3;
  localparam logic [IDX_W-1:0] REG_REFK  = 3'd4;
  localparam logic [IDX_W-1:0] REG_TARK  = 3'd5;
  localparam logic [IDX_W-1:0] REG_MINC  = 3'd6;

  // Pipeline stage numbers, counted in register stages after acceptance.
  localparam int unsigned ST_RAY_IN = 1;
  localparam int unsigned ST_RAY_Q  = 5;
  localparam int unsigned ST_GEOM   = 12;
  localparam int unsigned ST_DIV_IN = 13;
  localparam int unsigned ST_DIV_Q  = 21;
  localparam int unsigned PIPE_LAT  = 22;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_LOWC  = 2'd1,
    STATUS_DEGEN = 2'd2,
    STATUS_SAT   = 2'd3
  } status_e;

  // Flags that travel along the pipeline with each request.
  typedef struct packed {
    logic       valid;
    logic       low;
    logic       degen;
    logic       dsat1;
    logic       dsat2;
    logic [3:0] rneg;
    logic [3:0] rzero;
    logic [3:0] rsat;
  } side_t;

  function automatic logic signed [ELEM_W-1:0] field20(input logic [ROW_W-1:0] r,
                                                       input int unsigned k);
    return $signed(r[ELEM_W*k +: ELEM_W]);
  endfunction

  // Arithmetic right shift that truncates toward zero.
  function automatic logic signed [PRD_W-1:0] shr_tz(input logic signed [PRD_W-1:0] v,
                                                     input int unsigned sh);
    logic signed [PRD_W-1:0] bias;
    bias = v[PRD_W-1] ? ((48'sd1 <<< sh) - 48'sd1) : 48'sd0;
    return (v + bias) >>> sh;
  endfunction

endpackage

// ----- hw/rtl/tvjt_div.sv -----
// Pipelined restoring divider that retires STEPS quotient bits per stage.
`timescale 1ns / 1ps

module tvjt_div #(
  parameter int unsigned DEN_W = 16,
  parameter int unsigned QUO_W = 16,
  parameter int unsigned STEPS = 4
) (
  input  logic             clk_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [QUO_W-1:0] bits_i,
  output logic [QUO_W-1:0] quo_o
);

  localparam int unsigned NSTG = QUO_W / STEPS;

  logic [DEN_W-1:0] den_q [NSTG];
  logic [DEN_W-1:0] rem_q [NSTG];
  logic [QUO_W-1:0] quo_q [NSTG];
  logic [DEN_W-1:0] den_d [NSTG];
  logic [DEN_W-1:0] rem_d [NSTG];
  logic [QUO_W-1:0] quo_d [NSTG];
  logic [DEN_W-1:0] rv;
  logic [QUO_W-1:0] qv;
  logic [DEN_W:0]   trial;

  // The dividend bits shift out of the top of the quotient word while the
  // quotient bits shift in at the bottom.
  always_comb begin
    rv    = '0;
    qv    = '0;
    trial = '0;
    for (int k = 0; k < NSTG; k++) begin
      den_d[k] = (k == 0) ? den_i : den_q[k-1];
      rv       = (k == 0) ? rem_i : rem_q[k-1];
      qv       = (k == 0) ? bits_i : quo_q[k-1];
      for (int s = 0; s < STEPS; s++) begin
        trial = {rv, qv[QUO_W-1]};
        if (trial >= {1'b0, den_d[k]}) begin
          rv = DEN_W'(trial - {1'b0, den_d[k]});
          qv = {qv[QUO_W-2:0], 1'b1};
        end else begin
          rv = trial[DEN_W-1:0];
          qv = {qv[QUO_W-2:0], 1'b0};
        end
      end
      rem_d[k] = rv;
      quo_d[k] = qv;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTG; k++) begin
      den_q[k] <= den_d[k];
      rem_q[k] <= rem_d[k];
      quo_q[k] <= quo_d[k];
    end
  end

  assign quo_o = quo_q[NSTG-1];

endmodule

// ----- hw/rtl/tvjt_geom.sv -----
// Rotation, dot products, determinant and numerators of the two-ray system.
`timescale 1ns / 1ps

module tvjt_geom
  import tvjt_pkg::*;
(
  input  logic                     clk_i,
  input  logic [ROW_W-1:0]         rot0_i,
  input  logic [ROW_W-1:0]         rot1_i,
  input  logic [ROW_W-1:0]         rot2_i,
  input  logic [ROW_W-1:0]         trans_i,
  input  logic signed [RAY_W-1:0]  rx_i,
  input  logic signed [RAY_W-1:0]  ry_i,
  input  logic signed [RAY_W-1:0]  ax_i,
  input  logic signed [RAY_W-1:0]  ay_i,
  output logic signed [WIDE_W-1:0] det_o,
  output logic signed [WIDE_W-1:0] n1_o,
  output logic signed [WIDE_W-1:0] n2_o
);

  logic signed [RAY_W-1:0]  r_v [3];
  logic signed [RAY_W-1:0]  a_v [3];
  logic [ROW_W-1:0]         rot_v [3];
  logic signed [ELEM_W-1:0] t_v [3];

  // Stage one: rotation products.
  logic signed [RAY_W+ELEM_W-1:0] rp_q [3][3];
  logic signed [RAY_W-1:0]        a1_q [3];
  // Stage two: rotated reference ray.
  logic signed [B_W-1:0]          b_q [3];
  logic signed [RAY_W-1:0]        a2_q [3];
  // Stage three: terms of the five dot products.
  logic signed [PRD_W-1:0] aa_q [3];
  logic signed [PRD_W-1:0] ab_q [3];
  logic signed [PRD_W-1:0] bb_q [3];
  logic signed [PRD_W-1:0] at_q [3];
  logic signed [PRD_W-1:0] bt_q [3];
  // Stage four: dot products in Q.16.
  logic signed [DOT_W-1:0] p_q, q_q, s_q, g1_q, g2_q;
  // Stage five: cross products.
  logic signed [WIDE_W-1:0] ps_q, qq_q, sg1_q, qg2_q, pg2_q, qg1_q;
  // Stage six: results.
  logic signed [WIDE_W-1:0] det_q, n1_q, n2_q;

  logic signed [PRD_W-1:0] rsum [3];

  assign r_v[0] = rx_i;
  assign r_v[1] = ry_i;
  assign r_v[2] = RAY_ONE;
  assign rot_v[0] = rot0_i;
  assign rot_v[1] = rot1_i;
  assign rot_v[2] = rot2_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_v[i]  = field20(trans_i, i);
      a_v[i]  = (i == 2) ? RAY_ONE : a2_q[i];
      rsum[i] = PRD_W'(rp_q[i][0]) + PRD_W'(rp_q[i][1]) + PRD_W'(rp_q[i][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rp_q[i][j] <= field20(rot_v[i], j) * r_v[j];
      end
    end
    a1_q[0] <= ax_i;
    a1_q[1] <= ay_i;
    a1_q[2] <= RAY_ONE;

    for (int i = 0; i < 3; i++) begin
      b_q[i]  <= B_W'(shr_tz(rsum[i], 18));
      a2_q[i] <= a1_q[i];
    end

    for (int i = 0; i < 3; i++) begin
      aa_q[i] <= a_v[i] * a_v[i];
      ab_q[i] <= a_v[i] * b_q[i];
      bb_q[i] <= b_q[i] * b_q[i];
      at_q[i] <= a_v[i] * t_v[i];
      bt_q[i] <= b_q[i] * t_v[i];
    end

    p_q  <= DOT_W'(shr_tz(aa_q[0] + aa_q[1] + aa_q[2], 8));
    q_q  <= DOT_W'(shr_tz(ab_q[0] + ab_q[1] + ab_q[2], 8));
    s_q  <= DOT_W'(shr_tz(bb_q[0] + bb_q[1] + bb_q[2], 8));
    g1_q <= DOT_W'(shr_tz(at_q[0] + at_q[1] + at_q[2], 8));
    g2_q <= DOT_W'(shr_tz(bt_q[0] + bt_q[1] + bt_q[2], 8));

    ps_q  <= p_q * s_q;
    qq_q  <= q_q * q_q;
    sg1_q <= s_q * g1_q;
    qg2_q <= q_q * g2_q;
    pg2_q <= p_q * g2_q;
    qg1_q <= q_q * g1_q;

    det_q <= ps_q - qq_q;
    n1_q  <= sg1_q - qg2_q;
    n2_q  <= pg2_q - qg1_q;
  end

  assign det_o = det_q;
  assign n1_o  = n1_q;
  assign n2_o  = n2_q;

endmodule

// ----- hw/rtl/two_view_joint_triangulation_core.sv -----
// Top level of the two-view joint triangulation core.
//
// A request carries one joint seen by a reference and a target camera: two
// pixel positions and two confidences. It is taken at a rising edge with
// start high; busy is always low, so a new request may follow every cycle.
// The result (two depths in Q12.12 and a status code) appears on the output
// ports for exactly one cycle while done_o is high. Throughput is one
// request per cycle; a request passes through the four-stage ray dividers,
// the six-stage geometry pipeline and the eight stages of the depth
// dividers, which retire three quotient bits each. The receiver cannot
// stall, so the pipeline never holds. The user must write camera geometry
// and the confidence threshold through the cfg port only while no request
// is in flight; the core does not enforce this. Reset clears the pipeline
// flags and done_o, zeroes the camera registers, sets the threshold to 1.0.
`timescale 1ns / 1ps

module two_view_joint_triangulation_core
  import tvjt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [PIX_W-1:0]   ref_x_i,
  input  logic [PIX_W-1:0]   ref_y_i,
  input  logic [CONF_W-1:0]  ref_conf_i,
  input  logic [PIX_W-1:0]   tar_x_i,
  input  logic [PIX_W-1:0]   tar_y_i,
  input  logic [CONF_W-1:0]  tar_conf_i,
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  output logic               done_o,
  output logic [DEPTH_W-1:0] depth_first_o,
  output logic [DEPTH_W-1:0] depth_second_o,
  output logic [1:0]         status_o
);

  logic [ROW_W-1:0]  rot0_q, rot1_q, rot2_q, trans_q;
  logic [CFG_W-1:0]  refk_q, tark_q;
  logic [CONF_W-1:0] minc_q;

  side_t side_q [1:ST_DIV_Q];
  side_t side_d;
  side_t side_div;

  logic [PIX_W-1:0] pix_v [4];
  logic [PIX_W-1:0] cen_v [4];
  logic [PIX_W-1:0] foc_v [4];
  logic signed [PIX_W:0] diff_v [4];
  logic [PIX_W-1:0] mag_v [4];

  logic [PIX_W-1:0] rden_q [4];
  logic [PIX_W-1:0] rrem_q [4];
  logic [PIX_W-1:0] rbits_q [4];
  logic [PIX_W-1:0] rquo [4];
  logic signed [RAY_W-1:0] ray_q [4];

  logic signed [WIDE_W-1:0] det, n1, n2;
  logic [MAG_W-1:0] mag1, mag2;
  logic [DET_W-1:0] ddet_q;
  logic [DET_W-1:0] drem1_q, drem2_q;
  logic [DEPTH_W-1:0] dbits1_q, dbits2_q;
  logic [DEPTH_W-1:0] dquo1, dquo2;

  logic               done_q;
  logic [DEPTH_W-1:0] depth1_q, depth2_q;
  status_e            status_q;

  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot0_q  <= '0;
      rot1_q  <= '0;
      rot2_q  <= '0;
      trans_q <= '0;
      refk_q  <= '0;
      tark_q  <= '0;
      minc_q  <= CONF_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROT0:  rot0_q  <= cfg_data_i[ROW_W-1:0];
        REG_ROT1:  rot1_q  <= cfg_data_i[ROW_W-1:0];
        REG_ROT2:  rot2_q  <= cfg_data_i[ROW_W-1:0];
        REG_TRANS: trans_q <= cfg_data_i[ROW_W-1:0];
        REG_REFK:  refk_q  <= cfg_data_i;
        REG_TARK:  tark_q  <= cfg_data_i;
        REG_MINC:  minc_q  <= cfg_data_i[CONF_W-1:0];
        default: ;
      endcase
    end
  end

  // Ray normalization setup: component order is ref x, ref y, tar x, tar y.
  assign pix_v[0] = ref_x_i;
  assign pix_v[1] = ref_y_i;
  assign pix_v[2] = tar_x_i;
  assign pix_v[3] = tar_y_i;
  assign foc_v[0] = refk_q[15:0];
  assign foc_v[1] = refk_q[31:16];
  assign foc_v[2] = tark_q[15:0];
  assign foc_v[3] = tark_q[31:16];
  assign cen_v[0] = refk_q[47:32];
  assign cen_v[1] = refk_q[63:48];
  assign cen_v[2] = tark_q[47:32];
  assign cen_v[3] = tark_q[63:48];

  always_comb begin
    side_d       = '0;
    side_d.valid = start;
    side_d.low   = (ref_conf_i < minc_q) || (tar_conf_i < minc_q);
    for (int c = 0; c < 4; c++) begin
      diff_v[c] = $signed({1'b0, pix_v[c]}) - $signed({1'b0, cen_v[c]});
      mag_v[c]  = diff_v[c][PIX_W] ? PIX_W'(-diff_v[c]) : diff_v[c][PIX_W-1:0];
      side_d.rneg[c]  = diff_v[c][PIX_W];
      side_d.rzero[c] = (foc_v[c] == '0);
      // The quotient would exceed 16 bits.
      side_d.rsat[c]  = {4'b0, mag_v[c][PIX_W-1:4]} >= foc_v[c];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      rden_q[c]  <= foc_v[c];
      rrem_q[c]  <= {4'b0, mag_v[c][PIX_W-1:4]};
      rbits_q[c] <= {mag_v[c][3:0], 12'b0};
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_ray_div
    tvjt_div #(
      .DEN_W(PIX_W),
      .QUO_W(PIX_W),
      .STEPS(4)
    ) u_div (
      .clk_i (clk_i),
      .den_i (rden_q[c]),
      .rem_i (rrem_q[c]),
      .bits_i(rbits_q[c]),
      .quo_o (rquo[c])
    );
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      if (side_q[ST_RAY_Q].rzero[c]) begin
        ray_q[c] <= '0;
      end else if (side_q[ST_RAY_Q].rsat[c]) begin
        ray_q[c] <= side_q[ST_RAY_Q].rneg[c] ? -RAY_MAX : RAY_MAX;
      end else begin
        ray_q[c] <= side_q[ST_RAY_Q].rneg[c] ? -$signed({1'b0, rquo[c]})
                                             : $signed({1'b0, rquo[c]});
      end
    end
  end

  tvjt_geom u_geom (
    .clk_i  (clk_i),
    .rot0_i (rot0_q),
    .rot1_i (rot1_q),
    .rot2_i (rot2_q),
    .trans_i(trans_q),
    .rx_i   (ray_q[0]),
    .ry_i   (ray_q[1]),
    .ax_i   (ray_q[2]),
    .ay_i   (ray_q[3]),
    .det_o  (det),
    .n1_o   (n1),
    .n2_o   (n2)
  );

  // Depth division setup: the integer part must stay below 4096.
  assign mag1 = n1[WIDE_W-1] ? MAG_W'(-n1) : MAG_W'(n1);
  assign mag2 = n2[WIDE_W-1] ? MAG_W'(-n2) : MAG_W'(n2);

  always_ff @(posedge clk_i) begin
    ddet_q   <= det[DET_W-1:0];
    drem1_q  <= DET_W'(mag1[MAG_W-1:12]);
    drem2_q  <= DET_W'(mag2[MAG_W-1:12]);
    dbits1_q <= {mag1[11:0], 12'b0};
    dbits2_q <= {mag2[11:0], 12'b0};
  end

  tvjt_div #(
    .DEN_W(DET_W),
    .QUO_W(DEPTH_W),
    .STEPS(3)
  ) u_div_first (
    .clk_i (clk_i),
    .den_i (ddet_q),
    .rem_i (drem1_q),
    .bits_i(dbits1_q),
    .quo_o (dquo1)
  );

  tvjt_div #(
    .DEN_W(DET_W),
    .QUO_W(DEPTH_W),
    .STEPS(3)
  ) u_div_second (
    .clk_i (clk_i),
    .den_i (ddet_q),
    .rem_i (drem2_q),
    .bits_i(dbits2_q),
    .quo_o (dquo2)
  );

  // The geometry flags join the request as it enters the depth dividers.
  always_comb begin
    side_div       = side_q[ST_GEOM];
    side_div.degen = det < DET_MIN;
    side_div.dsat1 = DET_W'(mag1[MAG_W-1:12]) >= det[DET_W-1:0];
    side_div.dsat2 = DET_W'(mag2[MAG_W-1:12]) >= det[DET_W-1:0];
  end

  // Flags travel with each request; some are filled in at their stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = ST_RAY_IN; k <= ST_DIV_Q; k++) begin
        side_q[k] <= '0;
      end
    end else begin
      side_q[ST_RAY_IN] <= side_d;
      for (int k = ST_RAY_IN + 1; k <= ST_DIV_Q; k++) begin
        side_q[k] <= (k == ST_DIV_IN) ? side_div : side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side_q[ST_DIV_Q].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (side_q[ST_DIV_Q].low) begin
      depth1_q <= '0;
      depth2_q <= '0;
      status_q <= STATUS_LOWC;
    end else if (side_q[ST_DIV_Q].degen) begin
      depth1_q <= '0;
      depth2_q <= '0;
      status_q <= STATUS_DEGEN;
    end else begin
      depth1_q <= side_q[ST_DIV_Q].dsat1 ? DEPTH_SAT : dquo1;
      depth2_q <= side_q[ST_DIV_Q].dsat2 ? DEPTH_SAT : dquo2;
      status_q <= (side_q[ST_DIV_Q].dsat1 || side_q[ST_DIV_Q].dsat2) ? STATUS_SAT
                                                                      : STATUS_OK;
    end
  end

  assign done_o         = done_q;
  assign depth_first_o  = depth1_q;
  assign depth_second_o = depth2_q;
  assign status_o       = status_q;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench of the two-view joint triangulation core.
`timescale 1ns / 1ps

module testbench;
  import tvjt_pkg::*;

  localparam int unsigned RAND_ITEMS = 1130;
  localparam int unsigned SETTLE_CYCLES = PIPE_LAT + 8;
  // Index with no register behind it.
  localparam logic [IDX_W-1:0] REG_UNKNOWN = 3'd7;

  typedef struct packed {
    logic [DEPTH_W-1:0] d1;
    logic [DEPTH_W-1:0] d2;
    status_e            st;
  } depth_res_t;

  typedef struct packed {
    logic [PIX_W-1:0]  rx;
    logic [PIX_W-1:0]  ry;
    logic [CONF_W-1:0] rc;
    logic [PIX_W-1:0]  tx;
    logic [PIX_W-1:0]  ty;
    logic [CONF_W-1:0] tc;
  } joint_t;

  // One directed row: the joint, and an expected result where it is obvious.
  typedef struct packed {
    joint_t     j;
    logic       typed;
    depth_res_t res;
  } joint_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [PIX_W-1:0]   ref_x_i, ref_y_i, tar_x_i, tar_y_i;
  logic [CONF_W-1:0]  ref_conf_i, tar_conf_i;
  logic               cfg_we_i;
  logic [IDX_W-1:0]   cfg_index_i;
  logic [CFG_W-1:0]   cfg_data_i;
  logic               done_o;
  logic [DEPTH_W-1:0] depth_first_o, depth_second_o;
  logic [1:0]         status_o;

  two_view_joint_triangulation_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .ref_x_i       (ref_x_i),
    .ref_y_i       (ref_y_i),
    .ref_conf_i    (ref_conf_i),
    .tar_x_i       (tar_x_i),
    .tar_y_i       (tar_y_i),
    .tar_conf_i    (tar_conf_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .depth_first_o (depth_first_o),
    .depth_second_o(depth_second_o),
    .status_o      (status_o)
  );

  // Shadow copy of the camera geometry and the confidence threshold.
  logic [ROW_W-1:0]  rot_row[3];
  logic [ROW_W-1:0]  trans_reg;
  logic [CFG_W-1:0]  refk_reg, tark_reg;
  logic [CONF_W-1:0] minc_reg;

  depth_res_t pending_depths[$];
  int         fail_count;
  int         send_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  function automatic longint elem20(input logic [ROW_W-1:0] r, input int k);
    logic signed [19:0] v;
    v = r[20*k +: 20];
    return longint'(v);
  endfunction

  function automatic longint div_tz(input longint v, input int sh);
    if (v >= 0) return v >>> sh;
    return -((-v) >>> sh);
  endfunction

  function automatic longint norm_comp(input logic [PIX_W-1:0] pix, input logic [PIX_W-1:0] c,
                                       input logic [PIX_W-1:0] f);
    longint d, q;
    if (f == 0) return 0;
    d = longint'(pix) - longint'(c);
    q = ((d < 0 ? -d : d) << 12) / longint'(f);
    if (q > 65535) q = 65535;
    return d < 0 ? -q : q;
  endfunction

  function automatic logic [DEPTH_W-1:0] depth_quot(input longint n, input longint den,
                                                    output logic sat);
    longint num, iq, rem, frac;
    num = n < 0 ? -n : n;
    iq = num / den;
    rem = num % den;
    frac = 0;
    sat = 1'b0;
    if (iq >= 4096) begin
      sat = 1'b1;
      return DEPTH_SAT;
    end
    for (int i = 0; i < 12; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= den) begin
        rem -= den;
        frac |= 1;
      end
    end
    return DEPTH_W'((iq << 12) | frac);
  endfunction

  function automatic depth_res_t triangulate(input joint_t j);
    depth_res_t res;
    longint r[3], a[3], b[3], t[3];
    longint p, q, s, g1, g2, det, n1, n2, acc;
    logic s1, s2;
    res = '0;
    if (j.rc < minc_reg || j.tc < minc_reg) begin
      res.st = STATUS_LOWC;
      return res;
    end
    r[0] = norm_comp(j.rx, refk_reg[47:32], refk_reg[15:0]);
    r[1] = norm_comp(j.ry, refk_reg[63:48], refk_reg[31:16]);
    r[2] = 4096;
    a[0] = norm_comp(j.tx, tark_reg[47:32], tark_reg[15:0]);
    a[1] = norm_comp(j.ty, tark_reg[63:48], tark_reg[31:16]);
    a[2] = 4096;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += elem20(rot_row[i], k) * r[k];
      b[i] = div_tz(acc, 18);
      t[i] = elem20(trans_reg, i);
    end
    p = div_tz(a[0]*a[0] + a[1]*a[1] + a[2]*a[2], 8);
    q = div_tz(a[0]*b[0] + a[1]*b[1] + a[2]*b[2], 8);
    s = div_tz(b[0]*b[0] + b[1]*b[1] + b[2]*b[2], 8);
    g1 = div_tz(a[0]*t[0] + a[1]*t[1] + a[2]*t[2], 8);
    g2 = div_tz(b[0]*t[0] + b[1]*t[1] + b[2]*t[2], 8);
    det = p*s - q*q;
    if (det < 4295) begin
      res.st = STATUS_DEGEN;
      return res;
    end
    n1 = s*g1 - q*g2;
    n2 = p*g2 - q*g1;
    res.d1 = depth_quot(n1, det, s1);
    res.d2 = depth_quot(n2, det, s2);
    res.st = (s1 || s2) ? STATUS_SAT : STATUS_OK;
    return res;
  endfunction

  // Results are checked at the rising edge that ends their cycle.
  always @(posedge clk_i) begin
    depth_res_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_depths.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        exp_res = pending_depths.pop_front();
        if (depth_first_o !== exp_res.d1) begin
          $error("depth_first expected %0h actual %0h", exp_res.d1, depth_first_o);
          fail_count++;
        end
        if (depth_second_o !== exp_res.d2) begin
          $error("depth_second expected %0h actual %0h", exp_res.d2, depth_second_o);
          fail_count++;
        end
        if (status_o !== exp_res.st) begin
          $error("status expected %0d actual %0d", exp_res.st, status_o);
          fail_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_depths.size() != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    if (pending_depths.size() != 0) begin
      $error("results missing: %0d", pending_depths.size());
      fail_count++;
      pending_depths.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_ROT0:  rot_row[0] = val[ROW_W-1:0];
      REG_ROT1:  rot_row[1] = val[ROW_W-1:0];
      REG_ROT2:  rot_row[2] = val[ROW_W-1:0];
      REG_TRANS: trans_reg  = val[ROW_W-1:0];
      REG_REFK:  refk_reg   = val;
      REG_TARK:  tark_reg   = val;
      REG_MINC:  minc_reg   = val[CONF_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Presents one joint; start stays high when the next request follows at once.
  task automatic send_joint(input joint_t j, input logic typed, input depth_res_t res);
    ref_x_i    <= j.rx;
    ref_y_i    <= j.ry;
    ref_conf_i <= j.rc;
    tar_x_i    <= j.tx;
    tar_y_i    <= j.ty;
    tar_conf_i <= j.tc;
    start      <= 1'b1;
    do @(posedge clk_i); while (busy);
    pending_depths.insert(pending_depths.size(), typed ? res : triangulate(j));
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic logic [ROW_W-1:0] pack3(input int e0, input int e1, input int e2);
    return {20'(e2), 20'(e1), 20'(e0)};
  endfunction

  // Identity-like rotation, small random perturbation; fully random if extreme.
  task automatic load_camera_pair(input bit extreme);
    int one;
    one = 1 << 18;
    if (extreme) begin
      write_reg(REG_ROT0, {$urandom, $urandom});
      write_reg(REG_ROT1, {$urandom, $urandom});
      write_reg(REG_ROT2, {$urandom, $urandom});
      write_reg(REG_TRANS, {$urandom, $urandom});
      write_reg(REG_REFK, {$urandom, $urandom});
      write_reg(REG_TARK, {$urandom, $urandom});
    end else begin
      write_reg(REG_ROT0, CFG_W'(pack3(one - $urandom_range(4000),
                                       $urandom_range(40000) - 20000,
                                       $urandom_range(40000) - 20000)));
      write_reg(REG_ROT1, CFG_W'(pack3($urandom_range(40000) - 20000,
                                       one - $urandom_range(4000),
                                       $urandom_range(40000) - 20000)));
      write_reg(REG_ROT2, CFG_W'(pack3($urandom_range(40000) - 20000,
                                       $urandom_range(40000) - 20000,
                                       one - $urandom_range(4000))));
      write_reg(REG_TRANS, CFG_W'(pack3($urandom_range(8000000) - 4000000,
                                        $urandom_range(400000) - 200000,
                                        $urandom_range(400000) - 200000)));
      write_reg(REG_REFK, {16'($urandom_range(8000, 1000)), 16'($urandom_range(10000, 3000)),
                           16'($urandom_range(20000, 4000)), 16'($urandom_range(20000, 4000))});
      write_reg(REG_TARK, {16'($urandom_range(8000, 1000)), 16'($urandom_range(10000, 3000)),
                           16'($urandom_range(20000, 4000)), 16'($urandom_range(20000, 4000))});
    end
  endtask

  function automatic joint_t rand_joint(input bit wide);
    joint_t j;
    j = {$urandom, $urandom, $urandom};
    if (!wide) begin
      j.rx = 16'(refk_reg[47:32] + $urandom_range(4000) - 2000);
      j.ry = 16'(refk_reg[63:48] + $urandom_range(4000) - 2000);
      j.tx = 16'(tark_reg[47:32] + $urandom_range(4000) - 2000);
      j.ty = 16'(tark_reg[63:48] + $urandom_range(4000) - 2000);
      j.rc = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(65535, minc_reg));
      j.tc = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(65535, minc_reg));
    end
    return j;
  endfunction

  joint_row_t directed_rows[] = '{
    // Registers at reset: low confidence, then a zero geometry that is degenerate.
    '{'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '{24'd0, 24'd0, STATUS_LOWC}},
    '{'{16'hFFFF, 16'hFFFF, 16'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{24'd0, 24'd0, STATUS_LOWC}},
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4095}, 1'b1,
      '{24'd0, 24'd0, STATUS_LOWC}},
    '{'{16'd0, 16'd0, 16'd4096, 16'd0, 16'd0, 16'd4096}, 1'b1, '{24'd0, 24'd0, STATUS_DEGEN}},
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{24'd0, 24'd0, STATUS_DEGEN}}
  };

  initial begin
    joint_t     j;
    depth_res_t none;
    none = '0;
    fail_count = 0;
    send_idle_pct = 7;
    rot_row = '{default: '0};
    trans_reg = '0;
    refk_reg = '0;
    tark_reg = '0;
    minc_reg = CONF_RST;
    rst_ni = 1'b0;
    start = 1'b0;
    {ref_x_i, ref_y_i, ref_conf_i, tar_x_i, tar_y_i, tar_conf_i} = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) send_joint(directed_rows[i].j, directed_rows[i].typed,
                                          directed_rows[i].res);
    start <= 1'b0;
    wait_drained();

    // Plausible geometry: pixel extremes, wide rays and the lowest threshold.
    load_camera_pair(1'b0);
    write_reg(REG_MINC, 64'd0);
    send_joint('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, none);
    send_joint('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, none);
    send_joint('{16'h0000, 16'hFFFF, 16'h1000, 16'hFFFF, 16'h0000, 16'h1000}, 1'b0, none);
    for (int i = 0; i < 12; i++) send_joint(rand_joint(1'b0), 1'b0, none);
    start <= 1'b0;
    wait_drained();
    // Zero focal lengths, an unknown index, and the highest threshold.
    write_reg(REG_REFK, {16'd100, 16'd200, 16'd0, 16'd0});
    write_reg(REG_UNKNOWN, {$urandom, $urandom});
    write_reg(REG_MINC, 64'hFFFF);
    send_joint('{16'd5, 16'd5, 16'hFFFF, 16'd300, 16'd300, 16'hFFFF}, 1'b0, none);
    send_joint('{16'd5, 16'd5, 16'hFFFE, 16'd300, 16'd300, 16'hFFFF}, 1'b1,
               '{24'd0, 24'd0, STATUS_LOWC});
    start <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 80 : 0;
      for (int blk = 0; blk < 8; blk++) begin
        load_camera_pair(blk == 7);
        write_reg(REG_MINC, (blk == 0) ? 64'd0 : 64'($urandom_range(8192)));
        for (int i = 0; i < RAND_ITEMS / 24; i++) begin
          j = rand_joint($urandom_range(9) == 0);
          send_joint(j, 1'b0, none);
        end
        start <= 1'b0;
        wait_drained();
      end
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
